### sv/tcw_pkg.sv
// types and constants shared by the text console writer
package tcw_pkg;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [7:0] CODE_NULL    = 8'h00;
	localparam logic [7:0] CODE_NEWLINE = 8'h0a;
	localparam logic [7:0] CODE_SPACE   = 8'h20;

	localparam logic REG_ACTIVE_COLS = 1'b0;
	localparam logic REG_ACTIVE_ROWS = 1'b1;

	localparam logic [7:0] ACTIVE_COLS_RESET = 8'd50;
	localparam logic [5:0] ACTIVE_ROWS_RESET = 6'd10;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} req_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic       scrolled;
	} rsp_t;

endpackage

### sv/text_console_writer.sv
// text console writer: character store, cursor, wrap, scroll and clear
//
// requests arrive on req_valid/req_ready as a tcw_pkg::req_t item, and every
// item gives exactly one tcw_pkg::rsp_t item on rsp_valid/rsp_ready, in order.
// the user sets the active window size via wr_en/reg_index/wr_data while idle.
//
// steps per item, with one write and one read port on the character store:
//   put, newline, null code, unused command: result registered at acceptance
//   read: the registered store read, then the output register
//   clear: one store write of a space per active window cell, then a drain
//   put or newline that scrolls: one read and one write of the store per moved
//   cell, moving each row up through a one-stage write pipe, the bottom row
//   filled with spaces, then a drain
// after reset the whole store is swept to spaces with req_ready low;
// configuration writes are taken meanwhile; the block does not check idle.
// the result sits in an output register, so a new item is taken in the same
// cycle as the previous result leaves; a stalled receiver holds req_ready low
// only once the output register is full and not being drained.
module text_console_writer #(
	parameter int BUF_COLS = 128,
	parameter int BUF_ROWS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tcw_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tcw_pkg::rsp_t  rsp,
	input  logic           wr_en,
	input  logic           reg_index,
	input  logic [7:0]     wr_data
);

	localparam int COL_W  = $clog2(BUF_COLS);
	localparam int ROW_W  = $clog2(BUF_ROWS);
	localparam int DEPTH  = BUF_ROWS * BUF_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	// compare widths wide enough for both the register and the buffer size
	localparam int CCMP_W = (COL_W + 1 > 8) ? COL_W + 1 : 8;
	localparam int RCMP_W = (ROW_W + 1 > 6) ? ROW_W + 1 : 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_WALK,
		ST_DRAIN
	} state_t;

	function automatic logic [ADDR_W-1:0] cell_addr(
		input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c
	);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(r) * ADDR_W'(BUF_COLS);
		return base + ADDR_W'(c);
	endfunction

	// configuration
	logic [7:0] active_cols_q;
	logic [5:0] active_rows_q;

	// control
	state_t              state_q;
	logic [COL_W-1:0]    cur_col_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic                rsp_valid_q;
	tcw_pkg::rsp_t       rsp_q;
	tcw_pkg::rsp_t       pend_q;
	logic                rd_ok_q;

	// window walker: one cell of the window per cycle
	logic [COL_W-1:0]    wk_col_q;
	logic [ROW_W-1:0]    wk_row_q;
	logic [COL_W:0]      wk_lim_cols_q;
	logic [ROW_W:0]      wk_lim_rows_q;
	logic                wk_move_q;
	logic                wk_init_q;

	// write pipe stage behind the store read
	logic                wr_valid_s1;
	logic                wr_fill_s1;
	logic [ADDR_W-1:0]   wr_addr_s1;

	// character store
	logic [7:0]          store_mem [DEPTH];
	logic [7:0]          mem_rdata_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [7:0]          mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;

	// effective window size
	logic [CCMP_W-1:0]   ac_ext;
	logic [CCMP_W-1:0]   eff_cols_ext;
	logic [COL_W:0]      eff_cols;
	logic [RCMP_W-1:0]   ar_ext;
	logic [RCMP_W-1:0]   eff_rows_ext;
	logic [ROW_W:0]      eff_rows;

	// item decode
	logic                accept;
	logic                rsp_taken;
	logic                is_put;
	logic                is_newline;
	logic                put_write;
	logic [COL_W:0]      col_inc;
	logic [ROW_W:0]      row_inc;
	logic                adv_line;
	logic                scroll;
	logic [COL_W-1:0]    next_col;
	logic [ROW_W-1:0]    next_row;
	logic [ROW_W+4:0]    rd_row_ext;
	logic [COL_W+6:0]    rd_col_ext;
	logic                rd_in_range;
	logic [COL_W+6:0]    out_col_ext;
	logic [ROW_W+4:0]    out_row_ext;
	tcw_pkg::rsp_t       rsp_now;

	// walker step
	logic [COL_W:0]      wk_col_inc;
	logic [ROW_W:0]      wk_row_inc;
	logic                wk_row_end;
	logic                wk_last;
	logic                wk_is_move;

	assign ac_ext       = CCMP_W'(active_cols_q);
	assign eff_cols_ext = (ac_ext == '0) ? CCMP_W'(1) :
	                      (ac_ext > CCMP_W'(BUF_COLS)) ? CCMP_W'(BUF_COLS) : ac_ext;
	assign eff_cols     = eff_cols_ext[COL_W:0];
	assign ar_ext       = RCMP_W'(active_rows_q);
	assign eff_rows_ext = (ar_ext == '0) ? RCMP_W'(1) :
	                      (ar_ext > RCMP_W'(BUF_ROWS)) ? RCMP_W'(BUF_ROWS) : ar_ext;
	assign eff_rows     = eff_rows_ext[ROW_W:0];

	assign rsp_taken = rsp_valid_q && rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;

	// cursor update for a put item
	assign is_put     = (req.cmd == tcw_pkg::CMD_PUT);
	assign is_newline = is_put && (req.char_code == tcw_pkg::CODE_NEWLINE);
	assign put_write  = is_put && (req.char_code != tcw_pkg::CODE_NULL) && !is_newline;
	assign col_inc    = {1'b0, cur_col_q} + (COL_W+1)'(1);
	assign row_inc    = {1'b0, cur_row_q} + (ROW_W+1)'(1);
	assign adv_line   = is_newline || (put_write && (col_inc >= eff_cols));
	assign scroll     = adv_line && (row_inc >= eff_rows);

	always_comb begin
		next_col = cur_col_q;
		next_row = cur_row_q;
		if (adv_line) begin
			next_col = '0;
			if (scroll) begin
				next_row = ROW_W'(eff_rows - (ROW_W+1)'(1));
			end else begin
				next_row = row_inc[ROW_W-1:0];
			end
		end else if (put_write) begin
			next_col = col_inc[COL_W-1:0];
		end
	end

	// read address, cells outside the store read as zero
	assign rd_row_ext  = (ROW_W+5)'(req.read_row);
	assign rd_col_ext  = (COL_W+7)'(req.read_col);
	assign rd_in_range = (rd_row_ext < (ROW_W+5)'(BUF_ROWS)) &&
	                     (rd_col_ext < (COL_W+7)'(BUF_COLS));

	// result for the item being accepted, with the cursor after it
	assign out_col_ext = (COL_W+7)'(next_col);
	assign out_row_ext = (ROW_W+5)'(next_row);
	always_comb begin
		rsp_now            = '0;
		rsp_now.cursor_col = out_col_ext[6:0];
		rsp_now.cursor_row = out_row_ext[4:0];
		rsp_now.scrolled   = is_put && scroll;
	end

	// walker
	assign wk_col_inc = {1'b0, wk_col_q} + (COL_W+1)'(1);
	assign wk_row_inc = {1'b0, wk_row_q} + (ROW_W+1)'(1);
	assign wk_row_end = (wk_col_inc == wk_lim_cols_q);
	assign wk_last    = wk_row_end && (wk_row_inc == wk_lim_rows_q);
	assign wk_is_move = wk_move_q && (wk_row_inc < wk_lim_rows_q);

	// store ports: a put writes at acceptance, the write pipe only in a walk and its drain
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr(cur_row_q, cur_col_q);
		mem_wdata = req.char_code;
		if (accept && put_write) begin
			mem_we = 1'b1;
		end else if (wr_valid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_addr_s1;
			mem_wdata = wr_fill_s1 ? tcw_pkg::CODE_SPACE : mem_rdata_q;
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = cell_addr(wk_row_inc[ROW_W-1:0], wk_col_q);
		if (state_q == ST_WALK) begin
			mem_re = wk_is_move;
		end else if (accept && (req.cmd == tcw_pkg::CMD_READ)) begin
			mem_re    = rd_in_range;
			mem_raddr = cell_addr(rd_row_ext[ROW_W-1:0], rd_col_ext[COL_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= store_mem[mem_raddr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cols_q <= tcw_pkg::ACTIVE_COLS_RESET;
			active_rows_q <= tcw_pkg::ACTIVE_ROWS_RESET;
		end else if (wr_en) begin
			case (reg_index)
				tcw_pkg::REG_ACTIVE_COLS: active_cols_q <= wr_data;
				tcw_pkg::REG_ACTIVE_ROWS: active_rows_q <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	// control state, walker, write pipe and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// reset starts a sweep of the whole store to spaces
			state_q       <= ST_WALK;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			rsp_valid_q   <= 1'b0;
			wk_col_q      <= '0;
			wk_row_q      <= '0;
			wk_lim_cols_q <= (COL_W+1)'(BUF_COLS);
			wk_lim_rows_q <= (ROW_W+1)'(BUF_ROWS);
			wk_move_q     <= 1'b0;
			wk_init_q     <= 1'b1;
			wr_valid_s1   <= 1'b0;
			wr_fill_s1    <= 1'b0;
			wr_addr_s1    <= '0;
			rd_ok_q       <= 1'b0;
			pend_q        <= '0;
			rsp_q         <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					wr_valid_s1 <= 1'b0;
					if (accept) begin
						cur_col_q <= next_col;
						cur_row_q <= next_row;
						pend_q    <= rsp_now;
						if (req.cmd == tcw_pkg::CMD_READ) begin
							rd_ok_q     <= rd_in_range;
							rsp_valid_q <= 1'b0;
							state_q     <= ST_RD_WAIT;
						end else if ((req.cmd == tcw_pkg::CMD_CLEAR) || (is_put && scroll)) begin
							// walk the active window: move rows up, or fill
							wk_col_q      <= '0;
							wk_row_q      <= '0;
							wk_lim_cols_q <= eff_cols;
							wk_lim_rows_q <= eff_rows;
							wk_move_q     <= is_put;
							wk_init_q     <= 1'b0;
							rsp_valid_q   <= 1'b0;
							state_q       <= ST_WALK;
						end else begin
							rsp_q       <= rsp_now;
							rsp_valid_q <= 1'b1;
						end
					end else if (rsp_taken) begin
						rsp_valid_q <= 1'b0;
					end
				end
				ST_RD_WAIT: begin
					wr_valid_s1 <= 1'b0;
					rsp_q       <= {(rd_ok_q ? mem_rdata_q : 8'h00), pend_q.cursor_col,
					                pend_q.cursor_row, pend_q.scrolled};
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_WALK: begin
					// moved cells are written in the cycle after their source is read
					wr_valid_s1 <= 1'b1;
					wr_fill_s1  <= !wk_is_move;
					wr_addr_s1  <= cell_addr(wk_row_q, wk_col_q);
					if (wk_row_end) begin
						wk_col_q <= '0;
						wk_row_q <= wk_row_inc[ROW_W-1:0];
					end else begin
						wk_col_q <= wk_col_inc[COL_W-1:0];
					end
					if (wk_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					wr_valid_s1 <= 1'b0;
					if (!wk_init_q) begin
						rsp_q       <= pend_q;
						rsp_valid_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					wr_valid_s1 <= 1'b0;
					if (rsp_taken) begin
						rsp_valid_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a put write never meets a pending pipe write on the single write port
	assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && put_write && wr_valid_s1))
		else $error("store write port conflict");

	// a walker read is always followed by its write in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && mem_re) |=> (wr_valid_s1 && !wr_fill_s1))
		else $error("moved cell not written back");

	// the output register is empty while a read waits or a walk drains
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_WAIT || state_q == ST_DRAIN) |-> !rsp_valid_q)
		else $error("result register busy during item");

	// the cursor row never leaves the store
	assert property (@(posedge clk) disable iff (!arst_n)
		(ROW_W+1)'(cur_row_q) < (ROW_W+1)'(BUF_ROWS))
		else $error("cursor row outside store");

	// a scroll result always puts the cursor on column zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.scrolled) |-> (rsp_q.cursor_col == '0))
		else $error("scroll left cursor off column zero");

endmodule

### tb/sv/tb_text_console_writer.sv
// testbench for the text console writer: directed and random items checked against a console model
module tb_text_console_writer;
	import tcw_pkg::*;

	localparam int BUF_COLS = 128;
	localparam int BUF_ROWS = 32;

	// the one command code the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req       = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp;
	logic       wr_en     = 1'b0;
	logic       reg_index = REG_ACTIVE_COLS;
	logic [7:0] wr_data   = '0;

	text_console_writer #(
		.BUF_COLS(BUF_COLS),
		.BUF_ROWS(BUF_ROWS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.wr_en(wr_en),
		.reg_index(reg_index),
		.wr_data(wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hang guard, far beyond the slowest run this stimulus can take
	initial begin
		#100000000;
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------
	// console model: its own copy of the screen, cursor and window size
	// ---------------------------------------------------------------
	logic [7:0] screen [BUF_ROWS*BUF_COLS];
	int         cur_c;
	int         cur_r;
	logic [7:0] cfg_cols;
	logic [5:0] cfg_rows;

	// results still owed by the block, oldest first
	rsp_t pending_console_rsp[$];
	int   mismatch_count = 0;

	// percentage chance of an idle burst on either side
	int   idle_pct = 0;

	function automatic void reset_console_model();
		foreach (screen[i])
			screen[i] = CODE_SPACE;
		cur_c = 0;
		cur_r = 0;
		cfg_cols = ACTIVE_COLS_RESET;
		cfg_rows = ACTIVE_ROWS_RESET;
	endfunction

	// zero acts as one, oversize is clipped to the store
	function automatic int window_width();
		if (cfg_cols == 0)
			return 1;
		if (int'(cfg_cols) > BUF_COLS)
			return BUF_COLS;
		return int'(cfg_cols);
	endfunction

	function automatic int window_height();
		if (cfg_rows == 0)
			return 1;
		if (int'(cfg_rows) > BUF_ROWS)
			return BUF_ROWS;
		return int'(cfg_rows);
	endfunction

	// every active row moves up one, the bottom active row becomes blank
	function automatic void scroll_window();
		int w;
		int h;
		w = window_width();
		h = window_height();
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				screen[r*BUF_COLS + c] = (r + 1 == h) ? CODE_SPACE
					: screen[(r + 1)*BUF_COLS + c];
	endfunction

	function automatic void clear_window();
		for (int r = 0; r < window_height(); r++)
			for (int c = 0; c < window_width(); c++)
				screen[r*BUF_COLS + c] = CODE_SPACE;
	endfunction

	// carriage return plus line feed; tells whether the window scrolled
	function automatic logic advance_row();
		cur_c = 0;
		cur_r++;
		if (cur_r >= window_height()) begin
			scroll_window();
			cur_r = window_height() - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic rsp_t predict_console(req_t item);
		rsp_t res;
		res = '0;
		case (item.cmd)
			CMD_PUT: begin
				if (item.char_code == CODE_NEWLINE) begin
					res.scrolled = advance_row();
				end else if (item.char_code != CODE_NULL) begin
					// a cursor left outside a shrunk window still writes where it stands
					if (cur_r < BUF_ROWS && cur_c < BUF_COLS)
						screen[cur_r*BUF_COLS + cur_c] = item.char_code;
					cur_c++;
					if (cur_c >= window_width())
						res.scrolled = advance_row();
				end
			end
			CMD_CLEAR: begin
				clear_window();
			end
			CMD_READ: begin
				if (int'(item.read_row) < BUF_ROWS && int'(item.read_col) < BUF_COLS)
					res.cell_char = screen[int'(item.read_row)*BUF_COLS + int'(item.read_col)];
			end
			default: begin
				// unused command: nothing moves
			end
		endcase
		res.cursor_col = cur_c[6:0];
		res.cursor_row = cur_r[4:0];
		return res;
	endfunction

	// ---------------------------------------------------------------
	// result side: random back-pressure and the comparison
	// ---------------------------------------------------------------
	int unsigned stall_left = 0;

	// bursts with rsp_ready low, their length drawn at random
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(0, 13);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// values are taken as they stood just before the edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_console_rsp.size() == 0) begin
				$display("%0t: result item with nothing expected, actual %h", $time, rsp);
				mismatch_count++;
			end else begin
				want = pending_console_rsp.pop_front();
				check_field("cell_char", want.cell_char, rsp.cell_char);
				check_field("cursor_col", want.cursor_col, rsp.cursor_col);
				check_field("cursor_row", want.cursor_row, rsp.cursor_row);
				check_field("scrolled", want.scrolled, rsp.scrolled);
			end
		end
	end

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------
	function automatic req_t make_item(logic [1:0] cmd, logic [7:0] code,
		logic [4:0] row, logic [6:0] col);
		req_t item;
		item.cmd = cmd;
		item.char_code = code;
		item.read_row = row;
		item.read_col = col;
		return item;
	endfunction

	// holds the item until taken, then predicts its result
	task automatic send_item(input req_t item);
		if ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		pending_console_rsp.push_back(predict_console(item));
	endtask

	task automatic put_char(input logic [7:0] code);
		send_item(make_item(CMD_PUT, code, 5'($urandom), 7'($urandom)));
	endtask

	task automatic read_cell(input logic [4:0] row, input logic [6:0] col);
		send_item(make_item(CMD_READ, 8'($urandom), row, col));
	endtask

	task automatic clear_screen();
		send_item(make_item(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom)));
	endtask

	// always lets the clock move on before returning so back-to-back writes never clash
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_console_rsp.size() != 0);
	endtask

	// both registers in consecutive cycles, only with the block idle
	task automatic set_window(input logic [7:0] cols, input logic [5:0] rows);
		wait_drained();
		wr_en <= 1'b1;
		reg_index <= REG_ACTIVE_COLS;
		wr_data <= cols;
		@(posedge clk);
		reg_index <= REG_ACTIVE_ROWS;
		wr_data <= {2'b00, rows};
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_cols = cols;
		cfg_rows = rows;
	endtask

	// mostly text with line breaks and reads inside the window, a little of everything else
	function automatic req_t random_item();
		int pick;
		req_t item;
		pick = $urandom_range(0, 99);
		item = make_item(CMD_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
		if (pick < 62) begin
			if ($urandom_range(0, 9) == 0)
				item.char_code = CODE_NEWLINE;
			else if ($urandom_range(0, 29) == 0)
				item.char_code = CODE_NULL;
		end else if (pick < 90) begin
			item.cmd = CMD_READ;
			if ($urandom_range(0, 9) < 7) begin
				item.read_row = 5'($urandom_range(0, window_height() - 1));
				item.read_col = 7'($urandom_range(0, window_width() - 1));
			end
		end else if (pick < 94) begin
			item.cmd = CMD_CLEAR;
		end else if (pick < 97) begin
			item.cmd = CMD_UNUSED;
		end else begin
			// raw noise across every field
			item = make_item(2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
		end
		return item;
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// default window: extreme codes, the null code, reads and the unused command
	task automatic test_put_and_read();
		idle_pct = 20;
		put_char(8'h41);
		put_char(8'hff);
		put_char(8'h01);
		put_char(CODE_NULL);
		put_char(8'h80);
		read_cell(5'd0, 7'd0);
		read_cell(5'd0, 7'd5);
		read_cell(5'd31, 7'd127);
		send_item(make_item(CMD_UNUSED, 8'hff, 5'd31, 7'd127));
	endtask

	// zero sizes act as one: every put wraps and scrolls, cursor starts outside
	task automatic test_degenerate_window();
		set_window(8'd0, 6'd0);
		put_char(8'h42);
		read_cell(5'd0, 7'd0);
		read_cell(5'd0, 7'd4);
		put_char(CODE_NEWLINE);
		clear_screen();
		read_cell(5'd0, 7'd4);
	endtask

	// sizes beyond the store are clipped to the full store
	task automatic test_oversized_window();
		set_window(8'd255, 6'd63);
		put_char(8'h5a);
		read_cell(5'd0, 7'd0);
		put_char(CODE_NEWLINE);
		clear_screen();
		read_cell(5'd0, 7'd4);
	endtask

	// small window: wrap at the width, scroll past the last row
	task automatic test_wrap_and_scroll();
		set_window(8'd3, 6'd2);
		for (int i = 0; i < 7; i++)
			put_char(8'h61 + 8'(i));
		read_cell(5'd0, 7'd0);
		read_cell(5'd1, 7'd0);
	endtask

	// phases of random traffic, each under its own window size
	task automatic test_random_traffic();
		int count;
		for (int phase = 0; phase < 10; phase++) begin
			count = 170;
			idle_pct = (phase % 3 == 2) ? 0 : $urandom_range(5, 30);
			case (phase)
				3: begin
					set_window(8'd128, 6'd32);
					count = 60;
				end
				6: begin
					set_window(8'($urandom_range(129, 255)), 6'($urandom_range(33, 63)));
					count = 60;
				end
				8: set_window(8'd1, 6'd1);
				default: begin
					if ($urandom_range(0, 4) == 0)
						set_window(8'd0, 6'($urandom_range(0, 8)));
					else
						set_window(8'($urandom_range(1, 16)), 6'($urandom_range(1, 8)));
				end
			endcase
			repeat (count)
				send_item(random_item());
		end
	endtask

	// closing stretch with both sides always willing
	task automatic test_back_to_back();
		set_window(8'd16, 6'd4);
		idle_pct = 0;
		repeat (120)
			send_item(random_item());
	endtask

	task automatic finish_run();
		wait_drained();
		// room for any stray result to show up
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	endtask

	initial begin
		reset_console_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_put_and_read();
		test_degenerate_window();
		test_oversized_window();
		test_wrap_and_scroll();
		test_random_traffic();
		test_back_to_back();
		finish_run();
	end

endmodule
